// ===== rtl/stw_pkg.sv =====
// Shared types and constants for the swing-twist decomposition pipeline.
package stw_pkg;

  localparam int Q_W         = 16;
  localparam int V_W         = 18;
  localparam int LANES       = 4;
  localparam int DIV_STEPS   = 17;
  localparam int DIV_DEN_W   = 32;
  localparam int DIV_NUM_W   = DIV_DEN_W + DIV_STEPS;
  localparam int NORM_W      = 33;
  localparam int ROOT_W      = 31;
  localparam int SQRT_STEPS  = ROOT_W;
  localparam int SQ_REM_W    = ROOT_W + 2;
  localparam int FRAC_SHIFT  = 28;
  localparam int PAD_W       = 2 * SQRT_STEPS;

  localparam logic signed [Q_W-1:0] Q_ONE = 16'sd16384;

  typedef logic [1:0] status_t;
  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_SHORT    = 2'd1;
  localparam status_t STAT_SINGULAR = 2'd2;

  typedef struct packed {
    logic                    valid;
    status_t                 status;
    logic [LANES-1:0]        neg;
    logic signed [Q_W-1:0]   qw;
    logic signed [Q_W-1:0]   qx;
    logic signed [Q_W-1:0]   qy;
    logic signed [Q_W-1:0]   qz;
    logic signed [V_W-1:0]   vx;
    logic signed [V_W-1:0]   vy;
    logic signed [V_W-1:0]   vz;
  } side_t;

  typedef struct packed {
    logic signed [Q_W-1:0] sw;
    logic signed [Q_W-1:0] sx;
    logic signed [Q_W-1:0] sy;
    logic signed [Q_W-1:0] sz;
    logic signed [Q_W-1:0] tw;
    logic signed [Q_W-1:0] tx;
    logic signed [Q_W-1:0] ty;
    logic signed [Q_W-1:0] tz;
    status_t               status;
  } res_t;

endpackage

// ===== rtl/stw_div.sv =====
// Four-lane pipelined restoring divider, one quotient bit per stage, with sideband.
module stw_div (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   en,
  input  stw_pkg::side_t                                         side_in,
  input  logic [stw_pkg::LANES-1:0][stw_pkg::DIV_NUM_W-1:0]      num,
  input  logic [stw_pkg::DIV_DEN_W-1:0]                          den,
  output stw_pkg::side_t                                         side_out,
  output logic [stw_pkg::LANES-1:0][stw_pkg::DIV_STEPS-1:0]      quo
);

  stw_pkg::side_t                                        sd    [stw_pkg::DIV_STEPS+1];
  logic [stw_pkg::DIV_DEN_W-1:0]                         dn    [stw_pkg::DIV_STEPS];
  logic [stw_pkg::LANES-1:0][stw_pkg::DIV_DEN_W-1:0]     rem   [stw_pkg::DIV_STEPS];
  logic [stw_pkg::LANES-1:0][stw_pkg::DIV_STEPS-1:0]     nq    [stw_pkg::DIV_STEPS+1];
  logic [stw_pkg::LANES-1:0][stw_pkg::DIV_DEN_W-1:0]     rem_next [stw_pkg::DIV_STEPS];
  logic [stw_pkg::LANES-1:0][stw_pkg::DIV_STEPS-1:0]     nq_next  [stw_pkg::DIV_STEPS];

  always_comb begin
    for (int k = 0; k < stw_pkg::DIV_STEPS; k++) begin
      for (int l = 0; l < stw_pkg::LANES; l++) begin
        logic [stw_pkg::DIV_DEN_W:0] trial;
        trial = {rem[k][l], nq[k][l][stw_pkg::DIV_STEPS-1]};
        if (trial >= {1'b0, dn[k]}) begin
          rem_next[k][l] = stw_pkg::DIV_DEN_W'(trial - {1'b0, dn[k]});
          nq_next[k][l]  = {nq[k][l][stw_pkg::DIV_STEPS-2:0], 1'b1};
        end else begin
          rem_next[k][l] = trial[stw_pkg::DIV_DEN_W-1:0];
          nq_next[k][l]  = {nq[k][l][stw_pkg::DIV_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= stw_pkg::DIV_STEPS; k++) begin
        sd[k].valid <= 1'b0;
      end
    end else if (en) begin
      sd[0] <= side_in;
      dn[0] <= den;
      for (int l = 0; l < stw_pkg::LANES; l++) begin
        rem[0][l] <= num[l][stw_pkg::DIV_NUM_W-1:stw_pkg::DIV_STEPS];
        nq[0][l]  <= num[l][stw_pkg::DIV_STEPS-1:0];
      end
      for (int k = 1; k < stw_pkg::DIV_STEPS; k++) begin
        rem[k] <= rem_next[k-1];
        dn[k]  <= dn[k-1];
      end
      for (int k = 1; k <= stw_pkg::DIV_STEPS; k++) begin
        sd[k] <= sd[k-1];
        nq[k] <= nq_next[k-1];
      end
    end
  end

  assign side_out = sd[stw_pkg::DIV_STEPS];
  assign quo      = nq[stw_pkg::DIV_STEPS];

endmodule

// ===== rtl/stw_sqrt.sv =====
// Pipelined digit-by-digit integer square root of norm2 scaled by 2^28, with sideband.
module stw_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  stw_pkg::side_t                side_in,
  input  logic [stw_pkg::NORM_W-1:0]    norm2,
  output stw_pkg::side_t                side_out,
  output logic [stw_pkg::ROOT_W-1:0]    root_out
);

  stw_pkg::side_t                   sd   [stw_pkg::SQRT_STEPS+1];
  logic [stw_pkg::SQ_REM_W-1:0]     rem  [stw_pkg::SQRT_STEPS];
  logic [stw_pkg::ROOT_W-1:0]       root [stw_pkg::SQRT_STEPS+1];
  logic [stw_pkg::NORM_W-1:0]       nrm  [stw_pkg::SQRT_STEPS];
  logic [stw_pkg::SQ_REM_W-1:0]     rem_next  [stw_pkg::SQRT_STEPS];
  logic [stw_pkg::ROOT_W-1:0]       root_next [stw_pkg::SQRT_STEPS];

  always_comb begin
    for (int k = 0; k < stw_pkg::SQRT_STEPS; k++) begin
      logic [stw_pkg::PAD_W-1:0]      pad;
      logic [stw_pkg::SQ_REM_W+1:0]   tr;
      logic [stw_pkg::SQ_REM_W+1:0]   trial;
      pad   = {1'b0, nrm[k], {stw_pkg::FRAC_SHIFT{1'b0}}};
      tr    = {rem[k], pad[stw_pkg::PAD_W-1-2*k -: 2]};
      trial = {2'b00, root[k], 2'b01};
      if (tr >= trial) begin
        rem_next[k]  = stw_pkg::SQ_REM_W'(tr - trial);
        root_next[k] = {root[k][stw_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_next[k]  = tr[stw_pkg::SQ_REM_W-1:0];
        root_next[k] = {root[k][stw_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= stw_pkg::SQRT_STEPS; k++) begin
        sd[k].valid <= 1'b0;
      end
    end else if (en) begin
      sd[0]   <= side_in;
      rem[0]  <= '0;
      root[0] <= '0;
      nrm[0]  <= norm2;
      for (int k = 1; k < stw_pkg::SQRT_STEPS; k++) begin
        rem[k] <= rem_next[k-1];
        nrm[k] <= nrm[k-1];
      end
      for (int k = 1; k <= stw_pkg::SQRT_STEPS; k++) begin
        sd[k]   <= sd[k-1];
        root[k] <= root_next[k-1];
      end
    end
  end

  assign side_out = sd[stw_pkg::SQRT_STEPS];
  assign root_out = root[stw_pkg::SQRT_STEPS];

endmodule

// ===== rtl/swing_twist_decompose_core.sv =====
// Throughput: one beat per cycle; the pipeline freezes only while the output skid is full.
// Depth is set by two 17-stage dividers and a 31-stage square root, one bit per stage.
// Reset (rst, synchronous) clears all valid bits and the skid, and sets min_length to 1.
// Top level of the swing-twist decomposition pipeline.
module swing_twist_decompose_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [14:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] rot_w,
  input  logic signed [15:0] rot_x,
  input  logic signed [15:0] rot_y,
  input  logic signed [15:0] rot_z,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] swing_w,
  output logic signed [15:0] swing_x,
  output logic signed [15:0] swing_y,
  output logic signed [15:0] swing_z,
  output logic signed [15:0] twist_w,
  output logic signed [15:0] twist_x,
  output logic signed [15:0] twist_y,
  output logic signed [15:0] twist_z,
  output logic [1:0]         status
);

  function automatic logic signed [17:0] sgn18(input logic neg, input logic [16:0] mag);
    logic signed [17:0] m;
    m = $signed({1'b0, mag});
    return neg ? -m : m;
  endfunction

  function automatic logic signed [15:0] sat_q(input logic signed [19:0] x);
    logic signed [15:0] r;
    if (x > 20'sd32767) r = 16'sd32767;
    else if (x < -20'sd32768) r = -16'sd32768;
    else r = x[15:0];
    return r;
  endfunction

  function automatic logic signed [19:0] round_q14(input logic signed [33:0] s);
    logic        neg;
    logic [33:0] mag;
    logic [33:0] r;
    neg = s[33];
    mag = neg ? 34'(-s) : 34'(s);
    r   = (mag + 34'd8192) >> 14;
    return neg ? -$signed(r[19:0]) : $signed(r[19:0]);
  endfunction

  logic        en;
  logic [14:0] min_length;
  logic [29:0] m2;

  logic               a_v;
  logic signed [15:0] qa [4];
  logic signed [15:0] aa [3];

  logic               b_v;
  logic signed [15:0] qb [4];
  logic signed [15:0] ab [3];
  logic signed [31:0] bsq [3];
  logic signed [31:0] bdp [3];

  logic               c_v;
  logic signed [15:0] qc [4];
  logic signed [15:0] ac [3];
  logic [31:0]        c_len2;
  logic signed [32:0] c_d;
  logic               c_short;
  logic [31:0]        len2_next;
  logic signed [32:0] d_next;

  logic               d_v;
  logic signed [15:0] qd [4];
  logic [31:0]        d_len2;
  logic               d_short;
  logic signed [48:0] d_pd [3];

  stw_pkg::side_t                                        d1_in;
  stw_pkg::side_t                                        d1_out;
  logic [stw_pkg::LANES-1:0][stw_pkg::DIV_NUM_W-1:0]     d1_num;
  logic [stw_pkg::LANES-1:0][stw_pkg::DIV_STEPS-1:0]     d1_quo;

  stw_pkg::side_t     f_sd;
  stw_pkg::side_t     f_sd_next;
  stw_pkg::side_t     g_sd;
  logic [31:0]        g_sq [4];
  logic signed [31:0] wsq;
  logic signed [35:0] vsq [3];
  stw_pkg::side_t     h_sd;
  stw_pkg::side_t     h_sd_next;
  logic [32:0]        h_norm2;
  logic [33:0]        nsum;

  stw_pkg::side_t                                        sq_out;
  logic [stw_pkg::ROOT_W-1:0]                            sq_root;
  stw_pkg::side_t                                        d2_in;
  stw_pkg::side_t                                        d2_out;
  logic [stw_pkg::LANES-1:0][stw_pkg::DIV_NUM_W-1:0]     d2_num;
  logic [stw_pkg::LANES-1:0][stw_pkg::DIV_STEPS-1:0]     d2_quo;

  stw_pkg::side_t     j_sd;
  logic signed [15:0] j_t [4];
  logic signed [15:0] jq [4];
  stw_pkg::side_t     k_sd;
  logic signed [15:0] k_t [4];
  logic signed [31:0] k_p [4][4];
  stw_pkg::side_t     l_sd;
  logic signed [15:0] l_t [4];
  logic signed [33:0] l_s [4];

  logic           m_v;
  stw_pkg::res_t  m_res;
  stw_pkg::res_t  m_res_next;
  logic           ov;
  stw_pkg::res_t  od;
  logic           sv;
  stw_pkg::res_t  sd;

  assign en       = !sv;
  assign in_stall = sv;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= 15'd1;
      m2         <= 30'd1;
    end else begin
      if (cfg_wen) begin
        min_length <= cfg_wdata;
      end
      m2 <= 30'(min_length) * 30'(min_length);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
    end
  end

  assign len2_next = $unsigned(bsq[0]) + $unsigned(bsq[1]) + $unsigned(bsq[2]);
  assign d_next    = 33'(bdp[0]) + 33'(bdp[1]) + 33'(bdp[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      qa[0] <= rot_w;
      qa[1] <= rot_x;
      qa[2] <= rot_y;
      qa[3] <= rot_z;
      aa[0] <= axis_x;
      aa[1] <= axis_y;
      aa[2] <= axis_z;
      qb <= qa;
      ab <= aa;
      for (int i = 0; i < 3; i++) begin
        bsq[i] <= 32'(aa[i]) * 32'(aa[i]);
        bdp[i] <= 32'(qa[i+1]) * 32'(aa[i]);
      end
      qc      <= qb;
      ac      <= ab;
      c_len2  <= len2_next;
      c_d     <= d_next;
      c_short <= (len2_next == 32'd0) || (len2_next < {2'b00, m2});
      qd      <= qc;
      d_len2  <= c_len2;
      d_short <= c_short;
      for (int i = 0; i < 3; i++) begin
        d_pd[i] <= 49'(c_d) * 49'(ac[i]);
      end
    end
  end

  always_comb begin
    d1_in = '0;
    for (int l = 0; l < 3; l++) begin
      d1_in.neg[l] = d_pd[l][48];
      d1_num[l] = (d_pd[l][48] ? 49'(-d_pd[l]) : 49'(d_pd[l])) + 49'(d_len2 >> 1);
    end
    d1_num[3]     = '0;
    d1_in.valid   = d_v;
    d1_in.status  = d_short ? stw_pkg::STAT_SHORT : stw_pkg::STAT_OK;
    d1_in.qw      = qd[0];
    d1_in.qx      = qd[1];
    d1_in.qy      = qd[2];
    d1_in.qz      = qd[3];
  end

  stw_div u_div_proj (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (d1_in),
    .num      (d1_num),
    .den      (d_len2),
    .side_out (d1_out),
    .quo      (d1_quo)
  );

  assign wsq    = 32'(f_sd.qw) * 32'(f_sd.qw);
  assign vsq[0] = f_sd.vx * f_sd.vx;
  assign vsq[1] = f_sd.vy * f_sd.vy;
  assign vsq[2] = f_sd.vz * f_sd.vz;
  assign nsum   = 34'(g_sq[0]) + 34'(g_sq[1]) + 34'(g_sq[2]) + 34'(g_sq[3]);

  always_comb begin
    f_sd_next    = d1_out;
    f_sd_next.vx = sgn18(d1_out.neg[0], d1_quo[0]);
    f_sd_next.vy = sgn18(d1_out.neg[1], d1_quo[1]);
    f_sd_next.vz = sgn18(d1_out.neg[2], d1_quo[2]);
    h_sd_next    = g_sd;
    if (g_sd.status == stw_pkg::STAT_OK &&
        (nsum[32:0] == 33'd0 || nsum[32:0] < 33'(m2))) begin
      h_sd_next.status = stw_pkg::STAT_SINGULAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_sd.valid <= 1'b0;
      g_sd.valid <= 1'b0;
      h_sd.valid <= 1'b0;
    end else if (en) begin
      f_sd    <= f_sd_next;
      g_sd    <= f_sd;
      g_sq[0] <= $unsigned(wsq);
      for (int i = 0; i < 3; i++) begin
        g_sq[i+1] <= vsq[i][31:0];
      end
      h_sd    <= h_sd_next;
      h_norm2 <= nsum[32:0];
    end
  end

  stw_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (h_sd),
    .norm2    (h_norm2),
    .side_out (sq_out),
    .root_out (sq_root)
  );

  always_comb begin
    logic signed [17:0] c [4];
    logic signed [17:0] mag;
    c[0] = 18'(sq_out.qw);
    c[1] = sq_out.vx;
    c[2] = sq_out.vy;
    c[3] = sq_out.vz;
    d2_in = sq_out;
    for (int l = 0; l < stw_pkg::LANES; l++) begin
      d2_in.neg[l] = c[l][17];
      mag = c[l][17] ? -c[l] : c[l];
      d2_num[l] = (49'(mag[16:0]) << stw_pkg::FRAC_SHIFT) + 49'(sq_root >> 1);
    end
  end

  stw_div u_div_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (d2_in),
    .num      (d2_num),
    .den      ({1'b0, sq_root}),
    .side_out (d2_out),
    .quo      (d2_quo)
  );

  assign jq[0] = j_sd.qw;
  assign jq[1] = j_sd.qx;
  assign jq[2] = j_sd.qy;
  assign jq[3] = j_sd.qz;

  always_ff @(posedge clk) begin
    if (rst) begin
      j_sd.valid <= 1'b0;
      k_sd.valid <= 1'b0;
      l_sd.valid <= 1'b0;
    end else if (en) begin
      j_sd <= d2_out;
      for (int l = 0; l < stw_pkg::LANES; l++) begin
        j_t[l] <= sat_q(20'(sgn18(d2_out.neg[l], d2_quo[l])));
      end
      k_sd <= j_sd;
      k_t  <= j_t;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          k_p[i][j] <= 32'(jq[i]) * 32'(j_t[j]);
        end
      end
      l_sd   <= k_sd;
      l_t    <= k_t;
      l_s[0] <= 34'(k_p[0][0]) + 34'(k_p[1][1]) + 34'(k_p[2][2]) + 34'(k_p[3][3]);
      l_s[1] <= 34'(k_p[1][0]) - 34'(k_p[0][1]) - 34'(k_p[2][3]) + 34'(k_p[3][2]);
      l_s[2] <= 34'(k_p[1][3]) - 34'(k_p[0][2]) + 34'(k_p[2][0]) - 34'(k_p[3][1]);
      l_s[3] <= 34'(k_p[2][1]) - 34'(k_p[0][3]) - 34'(k_p[1][2]) + 34'(k_p[3][0]);
    end
  end

  always_comb begin
    m_res_next.status = l_sd.status;
    if (l_sd.status != stw_pkg::STAT_OK) begin
      m_res_next.sw = l_sd.qw;
      m_res_next.sx = l_sd.qx;
      m_res_next.sy = l_sd.qy;
      m_res_next.sz = l_sd.qz;
      m_res_next.tw = stw_pkg::Q_ONE;
      m_res_next.tx = '0;
      m_res_next.ty = '0;
      m_res_next.tz = '0;
    end else begin
      m_res_next.sw = sat_q(round_q14(l_s[0]));
      m_res_next.sx = sat_q(round_q14(l_s[1]));
      m_res_next.sy = sat_q(round_q14(l_s[2]));
      m_res_next.sz = sat_q(round_q14(l_s[3]));
      m_res_next.tw = l_t[0];
      m_res_next.tx = l_t[1];
      m_res_next.ty = l_t[2];
      m_res_next.tz = l_t[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (en) begin
      m_v <= l_sd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_res <= m_res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || !out_stall) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end else begin
        ov <= m_v;
      end
    end else if (m_v && !sv) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || !out_stall) begin
      od <= sv ? sd : m_res;
    end else if (m_v && !sv) begin
      sd <= m_res;
    end
  end

  assign out_valid = ov;
  assign swing_w   = od.sw;
  assign swing_x   = od.sx;
  assign swing_y   = od.sy;
  assign swing_z   = od.sz;
  assign twist_w   = od.tw;
  assign twist_x   = od.tx;
  assign twist_y   = od.ty;
  assign twist_z   = od.tz;
  assign status    = od.status;

endmodule

// ===== rtl/stw_checker.sv =====
// Port-level checker for the swing-twist decomposition core, bound to the top level.
module stw_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] twist_w,
  input logic signed [15:0] twist_x,
  input logic signed [15:0] twist_y,
  input logic signed [15:0] twist_z,
  input logic [1:0]         status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Output beat dropped while stalled.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == stw_pkg::STAT_OK || status == stw_pkg::STAT_SHORT ||
                  status == stw_pkg::STAT_SINGULAR)
    else $error("Undefined status code on output beat.");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != stw_pkg::STAT_OK |->
      twist_w == stw_pkg::Q_ONE && twist_x == 16'sd0 &&
      twist_y == 16'sd0 && twist_z == 16'sd0)
    else $error("Special case beat without identity twist.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("Input stalled without a stalled output.");

endmodule

bind swing_twist_decompose_core stw_checker u_stw_checker (.*);

// ===== tb/sv/swing_twist_decompose_core_tb.sv =====
// Self-checking testbench for the swing-twist decomposition pipeline.
`timescale 1ns / 100ps

module swing_twist_decompose_core_tb;

  typedef struct {
    logic signed [15:0] sw, sx, sy, sz, tw, tx, ty, tz;
    stw_pkg::status_t st;
  } split_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [14:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] rot_w = '0, rot_x = '0, rot_y = '0, rot_z = '0;
  logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] swing_w, swing_x, swing_y, swing_z;
  logic signed [15:0] twist_w, twist_x, twist_y, twist_z;
  logic [1:0] status;

  logic [14:0] thresh = 15'd1;
  split_t pending_splits[$];
  int errors = 0;
  int idle_pct = 18;
  int hold_cycles = 0;

  swing_twist_decompose_core dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .rot_w(rot_w), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
    .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .swing_w(swing_w), .swing_x(swing_x), .swing_y(swing_y), .swing_z(swing_z),
    .twist_w(twist_w), .twist_x(twist_x), .twist_y(twist_y), .twist_z(twist_z),
    .status(status)
  );

  always #2 clk = ~clk;

  function automatic longint div_round(longint n, longint d);
    longint mag, q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic split_t decompose(longint qw, longint qx, longint qy, longint qz,
                                       longint ax, longint ay, longint az);
    split_t r;
    longint unsigned m2, len2, nrm2, nq;
    longint d, vx, vy, vz, t0, t1, t2, t3, s0, s1, s2, s3;
    m2 = longint'(thresh) * longint'(thresh);
    r.sw = 16'(qw); r.sx = 16'(qx); r.sy = 16'(qy); r.sz = 16'(qz);
    r.tw = stw_pkg::Q_ONE; r.tx = '0; r.ty = '0; r.tz = '0;
    len2 = ax * ax + ay * ay + az * az;
    if (len2 == 0 || len2 < m2) begin
      r.st = stw_pkg::STAT_SHORT;
      return r;
    end
    d = qx * ax + qy * ay + qz * az;
    vx = div_round(d * ax, len2);
    vy = div_round(d * ay, len2);
    vz = div_round(d * az, len2);
    nrm2 = qw * qw + vx * vx + vy * vy + vz * vz;
    if (nrm2 == 0 || nrm2 < m2) begin
      r.st = stw_pkg::STAT_SINGULAR;
      return r;
    end
    nq = root_floor(nrm2 << 28);
    t0 = clamp16(div_round(qw <<< 28, nq));
    t1 = clamp16(div_round(vx <<< 28, nq));
    t2 = clamp16(div_round(vy <<< 28, nq));
    t3 = clamp16(div_round(vz <<< 28, nq));
    s0 =  qw * t0 + qx * t1 + qy * t2 + qz * t3;
    s1 = -qw * t1 + qx * t0 - qy * t3 + qz * t2;
    s2 = -qw * t2 + qx * t3 + qy * t0 - qz * t1;
    s3 = -qw * t3 - qx * t2 + qy * t1 + qz * t0;
    r.sw = clamp16(div_round(s0, 16384));
    r.sx = clamp16(div_round(s1, 16384));
    r.sy = clamp16(div_round(s2, 16384));
    r.sz = clamp16(div_round(s3, 16384));
    r.tw = 16'(t0); r.tx = 16'(t1); r.ty = 16'(t2); r.tz = 16'(t3);
    r.st = stw_pkg::STAT_OK;
    return r;
  endfunction

  task automatic send_pose(logic signed [15:0] w, x, y, z, ax, ay, az);
    while (($urandom_range(99) < idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rot_w <= w; rot_x <= x; rot_y <= y; rot_z <= z;
    axis_x <= ax; axis_y <= ay; axis_z <= az;
    pending_splits.push_back(decompose(w, x, y, z, ax, ay, az));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_splits.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_threshold(logic [14:0] v);
    drain();
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    thresh = v;
  endtask

  function automatic logic signed [15:0] rnd16();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return $urandom_range(64) - 32;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random_pose();
    logic signed [15:0] ax, ay, az;
    int k;
    ax = rnd16(); ay = rnd16(); az = rnd16();
    k = $urandom_range(9);
    if (k == 0) begin
      ax = $urandom_range(6) - 3; ay = $urandom_range(6) - 3; az = $urandom_range(6) - 3;
    end
    if (k == 1) send_pose($urandom_range(8) - 4, ay, az, -ax, ax, ay, az);
    else send_pose(rnd16(), rnd16(), rnd16(), rnd16(), ax, ay, az);
  endtask

  task automatic test_directed();
    send_pose(16384, 0, 0, 0, 0, 0, 16384);
    send_pose(11585, 0, 0, 11585, 0, 0, 16384);
    send_pose(11585, 11585, 0, 0, 0, 0, 16384);
    send_pose(0, 0, 0, 16384, 0, 0, 16384);
    send_pose(0, 16384, 0, 0, 0, 0, 16384);
    send_pose(8192, 8192, 8192, 8192, 0, 0, 0);
    send_pose(8192, 8192, 8192, 8192, 1, 0, 0);
    send_pose(32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_pose(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_pose(-32768, 32767, -32768, 32767, -32768, 32767, -32768);
    send_pose(0, 0, 0, 0, 100, 200, 300);
    send_pose(1, 0, 0, 0, 0, 16384, 0);
    send_pose(-5, 3, -7, 11, 3, -5, 7);
    send_pose(32767, -32768, 0, 100, 0, -1, 1);
  endtask

  task automatic test_thresholds();
    logic [14:0] vals[4] = '{15'd0, 15'd32767, 15'd200, 15'd1};
    foreach (vals[i]) begin
      set_threshold(vals[i]);
      send_pose(0, 0, 0, 0, 0, 0, 0);
      send_pose(100, 50, 0, 0, 0, 150, 0);
      send_pose(0, 16384, 0, 0, 16384, 0, 0);
      repeat (40) send_random_pose();
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 300;
    idle_pct = 0;
    repeat (150) send_random_pose();
    drain();
    idle_pct = 18;
  endtask

  task automatic test_random();
    repeat (200) send_random_pose();
    idle_pct = 0;
    repeat (150) send_random_pose();
    idle_pct = 18;
    repeat (150) send_random_pose();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    split_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_splits.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        errors++;
      end else begin
        e = pending_splits.pop_front();
        if ({swing_w, swing_x, swing_y, swing_z, twist_w, twist_x, twist_y, twist_z,
             status} !== {e.sw, e.sx, e.sy, e.sz, e.tw, e.tx, e.ty, e.tz, e.st}) begin
          $display("%0t: expected swing %0d %0d %0d %0d twist %0d %0d %0d %0d st %0d",
                   $time, e.sw, e.sx, e.sy, e.sz, e.tw, e.tx, e.ty, e.tz, e.st);
          $display("%0t: actual   swing %0d %0d %0d %0d twist %0d %0d %0d %0d st %0d",
                   $time, swing_w, swing_x, swing_y, swing_z,
                   twist_w, twist_x, twist_y, twist_z, status);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_thresholds();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
